// File: hw/rtl/kpl_pkg.sv
// Shared types, constants and decode functions for the keypad passcode lock.
package kpl_pkg;

   localparam int KEY_W       = 8;
   localparam int DIGIT_W     = 6;
   localparam int CHAR_W      = 7;
   localparam int CODE_LENGTH = 3;
   localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam int MAX_RESULTS = 3;
   localparam int SLOT_W      = $clog2(MAX_RESULTS);
   localparam int CSR_IDX_W   = 2;

   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CODE_LENGTH - 1);

   localparam logic [CHAR_W-1:0] BELL_CHAR = 7'h07;
   localparam logic [CHAR_W-1:0] ERR_CHAR  = 7'h45;
   localparam logic [CHAR_W-1:0] HASH_CHAR = 7'h23;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CODE_FIRST  = 2'd0,
      CSR_CODE_SECOND = 2'd1,
      CSR_CODE_THIRD  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] first;
      logic [DIGIT_W-1:0] second;
      logic [DIGIT_W-1:0] third;
   } code_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] value;
      logic [CHAR_W-1:0]  ch;
   } key_type;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              locked;
      logic              last_result;
   } rsp_word_type;

   typedef rsp_word_type [MAX_RESULTS-1:0] burst_type;

   function automatic key_type decode_key(logic [KEY_W-1:0] code);
      key_type k;
      case (code)
         8'h84:   k = '{value: 6'h00, ch: 7'h30};
         8'h18:   k = '{value: 6'h01, ch: 7'h31};
         8'h14:   k = '{value: 6'h02, ch: 7'h32};
         8'h12:   k = '{value: 6'h03, ch: 7'h33};
         8'h28:   k = '{value: 6'h04, ch: 7'h34};
         8'h24:   k = '{value: 6'h05, ch: 7'h35};
         8'h22:   k = '{value: 6'h06, ch: 7'h36};
         8'h48:   k = '{value: 6'h07, ch: 7'h37};
         8'h44:   k = '{value: 6'h08, ch: 7'h38};
         8'h42:   k = '{value: 6'h09, ch: 7'h39};
         8'h11:   k = '{value: 6'h0A, ch: 7'h41};
         8'h21:   k = '{value: 6'h0B, ch: 7'h42};
         8'h41:   k = '{value: 6'h0C, ch: 7'h43};
         8'h81:   k = '{value: 6'h0D, ch: 7'h44};
         8'h88:   k = '{value: 6'h2A, ch: 7'h2A};
         8'h82:   k = '{value: 6'h23, ch: 7'h23};
         default: k = '{value: 6'h0F, ch: 7'h46};
      endcase
      return k;
   endfunction

   // positions past the third expect key value 0
   function automatic logic [DIGIT_W-1:0] expected_digit(code_type code, int unsigned pos);
      logic [DIGIT_W-1:0] d;
      case (pos)
         0:       d = code.first;
         1:       d = code.second;
         2:       d = code.third;
         default: d = '0;
      endcase
      return d;
   endfunction

endpackage

// File: hw/rtl/kpl_ifs.sv
// Valid/ready channel interfaces for key presses and display words.
interface kpl_req_if;
   logic                        valid;
   logic                        ready;
   logic [kpl_pkg::KEY_W-1:0]   key_code;

   modport source (output valid, output key_code, input ready);
   modport sink   (input valid, input key_code, output ready);
endinterface

interface kpl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [kpl_pkg::CHAR_W-1:0]  out_char;
   logic                        locked;
   logic                        last_result;

   modport source (output valid, output out_char, output locked, output last_result,
                   input ready);
   modport sink   (input valid, input out_char, input locked, input last_result,
                   output ready);
endinterface

// File: hw/rtl/kpl_press.sv
// Press decode, lock state and entered digits; builds the result words of one press.
module kpl_press (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [kpl_pkg::KEY_W-1:0]   key_code,
   input  kpl_pkg::code_type           code,
   output kpl_pkg::burst_type          words
);

   logic                                 lock_mode_ff, lock_mode_in;
   logic [kpl_pkg::IDX_W-1:0]            count_ff, count_in;
   logic [kpl_pkg::DIGIT_W-1:0]          digits_ff [kpl_pkg::CODE_LENGTH];
   kpl_pkg::key_type                     key;
   logic                                 is_last;
   logic                                 match;

   assign key     = kpl_pkg::decode_key(key_code);
   assign is_last = (count_ff == kpl_pkg::LAST_IDX);

   // last digit of the round is compared straight from the incoming press
   always_comb begin
      match = 1'b1;
      for (int i = 0; i < kpl_pkg::CODE_LENGTH; i++) begin
         if (i == kpl_pkg::CODE_LENGTH - 1) begin
            if (key.value != kpl_pkg::expected_digit(code, i)) match = 1'b0;
         end else begin
            if (digits_ff[i] != kpl_pkg::expected_digit(code, i)) match = 1'b0;
         end
      end
   end

   always_comb begin
      words        = '0;
      lock_mode_in = lock_mode_ff;
      count_in     = count_ff;
      if (!lock_mode_ff) begin
         if (key.ch == kpl_pkg::HASH_CHAR) begin
            words[0]     = '{out_char: key.ch, locked: 1'b0, last_result: 1'b0};
            words[1]     = '{out_char: kpl_pkg::HASH_CHAR, locked: 1'b1, last_result: 1'b1};
            lock_mode_in = 1'b1;
            count_in     = '0;
         end else begin
            words[0] = '{out_char: key.ch, locked: 1'b0, last_result: 1'b1};
         end
      end else if (!is_last) begin
         words[0] = '{out_char: key.ch, locked: 1'b1, last_result: 1'b1};
         count_in = count_ff + kpl_pkg::IDX_W'(1);
      end else begin
         words[0] = '{out_char: key.ch, locked: 1'b1, last_result: 1'b0};
         count_in = '0;
         if (match) begin
            words[1]     = '{out_char: kpl_pkg::BELL_CHAR, locked: 1'b0, last_result: 1'b1};
            lock_mode_in = 1'b0;
         end else begin
            words[1] = '{out_char: kpl_pkg::ERR_CHAR, locked: 1'b1, last_result: 1'b0};
            words[2] = '{out_char: kpl_pkg::HASH_CHAR, locked: 1'b1, last_result: 1'b1};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_mode_ff <= 1'b1;
         count_ff     <= '0;
      end else if (accept) begin
         lock_mode_ff <= lock_mode_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && lock_mode_ff) begin
         digits_ff[count_ff] <= key.value;
      end
   end

endmodule

// File: hw/rtl/kpl_burst.sv
// Result buffer: holds the words of one press and hands them out one per cycle while rsp.ready is high.
module kpl_burst (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  kpl_pkg::burst_type   words,
   output logic                 can_load,
   kpl_rsp_if.source            rsp
);

   logic                          valid_ff, valid_in;
   logic [kpl_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   kpl_pkg::burst_type            words_ff;
   kpl_pkg::rsp_word_type         cur;
   logic                          fire;

   assign cur             = words_ff[slot_ff];
   assign rsp.valid       = valid_ff;
   assign rsp.out_char    = cur.out_char;
   assign rsp.locked      = cur.locked;
   assign rsp.last_result = cur.last_result;

   assign fire     = valid_ff && rsp.ready;
   // free once the final word of the held press goes out
   assign can_load = !valid_ff || (fire && cur.last_result);

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      if (load) begin
         valid_in = 1'b1;
         slot_in  = '0;
      end else if (fire) begin
         if (cur.last_result) valid_in = 1'b0;
         else slot_in = slot_ff + kpl_pkg::SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) words_ff <= words;
   end

endmodule

// File: hw/rtl/keypad_passcode_lock.sv
// Keypad passcode lock top level: code registers, press logic and result buffer.
// Each accepted press word is a raw 4x4 keypad code (columns high nibble, rows low)
// and yields one to three result words: one for a plain press, two for the
// final press of a correct code (echo, bell) or for a relocking '#' press, and
// three for the final press of a wrong code (echo, 'E', '#'). The press is
// decoded and its state update done in the cycle it is accepted; its words then
// leave a result buffer one per cycle while the display side is ready, and the
// next press is taken in the same cycle as the last word of the previous one goes
// out. The three code digits are written through the csr port at indexes 0 to 2
// and reset to 1, 2, 3; writes to index 3 are dropped.
module keypad_passcode_lock (
   input  logic                             clock,
   input  logic                             reset,
   kpl_req_if.sink                          req_bus,
   kpl_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [kpl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [kpl_pkg::DIGIT_W-1:0]      csr_wdata
);

   kpl_pkg::code_type    code_ff, code_in;
   kpl_pkg::burst_type   words;
   logic                 can_load;
   logic                 accept;

   assign req_bus.ready = can_load;
   assign accept        = req_bus.valid && can_load;

   always_comb begin
      code_in = code_ff;
      if (csr_we) begin
         case (kpl_pkg::csr_index_type'(csr_index))
            kpl_pkg::CSR_CODE_FIRST:  code_in.first  = csr_wdata;
            kpl_pkg::CSR_CODE_SECOND: code_in.second = csr_wdata;
            kpl_pkg::CSR_CODE_THIRD:  code_in.third  = csr_wdata;
            default:                  code_in        = code_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= '{first: 6'd1, second: 6'd2, third: 6'd3};
      end else begin
         code_ff <= code_in;
      end
   end

   kpl_press u_press (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .key_code (req_bus.key_code),
      .code     (code_ff),
      .words    (words)
   );

   kpl_burst u_burst (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .words    (words),
      .can_load (can_load),
      .rsp      (rsp_bus)
   );

endmodule

// File: dv/tb_keypad_passcode_lock.sv
// Self-checking testbench for the keypad passcode lock: key presses in, display words checked.
`timescale 1ns / 1ps

module tb_keypad_passcode_lock;

   localparam logic [kpl_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam logic [kpl_pkg::KEY_W-1:0]     HASH_KEY     = 8'h82;
   localparam logic [kpl_pkg::DIGIT_W-1:0]   INVALID_KEY  = 6'h0F;
   localparam logic [kpl_pkg::CHAR_W-1:0]    INVALID_CHAR = 7'h46;
   // grid codes in key order: digits 0-9, A-D, '*', '#'
   localparam logic [15:0][kpl_pkg::KEY_W-1:0] KEY_CODES = {
      8'h82, 8'h88, 8'h81, 8'h41, 8'h21, 8'h11, 8'h42, 8'h44,
      8'h48, 8'h22, 8'h24, 8'h28, 8'h12, 8'h14, 8'h18, 8'h84};

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          press_valid = 1'b0;
   logic [kpl_pkg::KEY_W-1:0]     press_code  = '0;
   logic                          word_ready  = 1'b0;
   logic                          csr_we      = 1'b0;
   logic [kpl_pkg::CSR_IDX_W-1:0] csr_index   = kpl_pkg::CSR_CODE_FIRST;
   logic [kpl_pkg::DIGIT_W-1:0]   csr_wdata   = '0;

   kpl_req_if req_bus();
   kpl_rsp_if rsp_bus();

   assign req_bus.valid    = press_valid;
   assign req_bus.key_code = press_code;
   assign rsp_bus.ready    = word_ready;

   keypad_passcode_lock uut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   logic [kpl_pkg::KEY_W-1:0]   pending_keys [$];
   kpl_pkg::rsp_word_type       expected_words [$];
   int                          presses_queued = 0;
   int                          presses_taken  = 0;
   int                          errors         = 0;
   bit                          calm           = 1'b0;
   logic                        press_taken    = 1'b0;
   int                          gap_left       = 0;
   int                          stall_left     = 0;

   // lock state as the block should hold it
   logic [kpl_pkg::DIGIT_W-1:0] lock_code [3] = '{6'd1, 6'd2, 6'd3};
   logic                        held_locked    = 1'b1;
   int unsigned                 digits_entered = 0;
   logic [kpl_pkg::DIGIT_W-1:0] entered [kpl_pkg::CODE_LENGTH];

   function automatic void key_lookup(input logic [kpl_pkg::KEY_W-1:0] code,
                                      output logic [kpl_pkg::DIGIT_W-1:0] value,
                                      output logic [kpl_pkg::CHAR_W-1:0] ch);
      value = INVALID_KEY;
      ch    = INVALID_CHAR;
      for (int i = 0; i < 16; i++) begin
         if (KEY_CODES[i] == code) begin
            if (i < 10) begin
               value = kpl_pkg::DIGIT_W'(i);
               ch    = 7'h30 + kpl_pkg::CHAR_W'(i);
            end else if (i < 14) begin
               value = kpl_pkg::DIGIT_W'(i);
               ch    = 7'h41 + kpl_pkg::CHAR_W'(i - 10);
            end else if (i == 14) begin
               value = 6'h2A;
               ch    = 7'h2A;
            end else begin
               value = 6'h23;
               ch    = kpl_pkg::HASH_CHAR;
            end
         end
      end
   endfunction

   function automatic logic [kpl_pkg::DIGIT_W-1:0] code_digit(input int pos);
      return (pos < 3) ? lock_code[pos] : '0;
   endfunction

   function automatic kpl_pkg::rsp_word_type display_word(input logic [kpl_pkg::CHAR_W-1:0] ch,
                                                          input logic lk, input logic last);
      kpl_pkg::rsp_word_type w;
      w.out_char    = ch;
      w.locked      = lk;
      w.last_result = last;
      return w;
   endfunction

   function automatic void apply_press(input logic [kpl_pkg::KEY_W-1:0] code);
      logic [kpl_pkg::DIGIT_W-1:0] value;
      logic [kpl_pkg::CHAR_W-1:0]  ch;
      bit                          matched;
      key_lookup(code, value, ch);
      if (!held_locked) begin
         if (ch == kpl_pkg::HASH_CHAR) begin
            expected_words.push_back(display_word(ch, 1'b0, 1'b0));
            expected_words.push_back(display_word(kpl_pkg::HASH_CHAR, 1'b1, 1'b1));
            held_locked    = 1'b1;
            digits_entered = 0;
         end else begin
            expected_words.push_back(display_word(ch, 1'b0, 1'b1));
         end
      end else begin
         entered[digits_entered] = value;
         digits_entered++;
         if (digits_entered < kpl_pkg::CODE_LENGTH) begin
            expected_words.push_back(display_word(ch, 1'b1, 1'b1));
         end else begin
            digits_entered = 0;
            expected_words.push_back(display_word(ch, 1'b1, 1'b0));
            matched = 1'b1;
            for (int i = 0; i < kpl_pkg::CODE_LENGTH; i++)
               if (entered[i] != code_digit(i)) matched = 1'b0;
            if (matched) begin
               held_locked = 1'b0;
               expected_words.push_back(display_word(kpl_pkg::BELL_CHAR, 1'b0, 1'b1));
            end else begin
               expected_words.push_back(display_word(kpl_pkg::ERR_CHAR, 1'b1, 1'b0));
               expected_words.push_back(display_word(kpl_pkg::HASH_CHAR, 1'b1, 1'b1));
            end
         end
      end
   endfunction

   // press driver
   always @(negedge clock) begin
      if (reset) begin
         press_valid <= 1'b0;
      end else if (press_valid && !press_taken) begin
         press_valid <= 1'b1;
      end else if (gap_left > 0) begin
         press_valid <= 1'b0;
         gap_left    <= gap_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         press_valid <= 1'b0;
         gap_left    <= int'($urandom_range(0, 14));
      end else if (pending_keys.size() > 0) begin
         press_valid <= 1'b1;
         press_code  <= pending_keys.pop_front();
      end else begin
         press_valid <= 1'b0;
      end
   end

   // display side backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         word_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         word_ready <= 1'b0;
         stall_left <= int'($urandom_range(0, 14));
      end else begin
         word_ready <= 1'b1;
      end
   end

   // monitor: check outgoing words, predict on accepted presses
   always @(posedge clock) begin
      kpl_pkg::rsp_word_type got;
      kpl_pkg::rsp_word_type want;
      if (reset) begin
         press_taken <= 1'b0;
      end else begin
         press_taken <= press_valid && req_bus.ready;
         if (rsp_bus.valid && word_ready) begin
            got = display_word(rsp_bus.out_char, rsp_bus.locked, rsp_bus.last_result);
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual char %h locked %b last %b",
                        $time, got.out_char, got.locked, got.last_result);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (got.out_char !== want.out_char) begin
                  $display("%0t: out_char expected %h actual %h",
                           $time, want.out_char, got.out_char);
                  errors++;
               end
               if (got.locked !== want.locked) begin
                  $display("%0t: locked expected %b actual %b", $time, want.locked, got.locked);
                  errors++;
               end
               if (got.last_result !== want.last_result) begin
                  $display("%0t: last_result expected %b actual %b",
                           $time, want.last_result, got.last_result);
                  errors++;
               end
            end
         end
         if (press_valid && req_bus.ready) begin
            apply_press(press_code);
            presses_taken++;
         end
      end
   end

   function automatic logic [kpl_pkg::KEY_W-1:0] random_key();
      if ($urandom_range(0, 1) == 0) return KEY_CODES[$urandom_range(0, 15)];
      return kpl_pkg::KEY_W'($urandom_range(0, 255));
   endfunction

   // pick a raw code that decodes to the wanted key value, if any exists
   function automatic logic [kpl_pkg::KEY_W-1:0] code_for(
         input logic [kpl_pkg::DIGIT_W-1:0] want, output bit found);
      logic [kpl_pkg::KEY_W-1:0]   hits [$];
      logic [kpl_pkg::DIGIT_W-1:0] value;
      logic [kpl_pkg::CHAR_W-1:0]  ch;
      for (int c = 0; c < 256; c++) begin
         key_lookup(kpl_pkg::KEY_W'(c), value, ch);
         if (value == want) hits.push_back(kpl_pkg::KEY_W'(c));
      end
      found = hits.size() > 0;
      return found ? hits[$urandom_range(0, hits.size() - 1)] : '0;
   endfunction

   task automatic queue_press(input logic [kpl_pkg::KEY_W-1:0] code);
      pending_keys.push_back(code);
      presses_queued++;
   endtask

   // one full code entry; a wrong one gets a guaranteed bad digit somewhere
   task automatic queue_attempt(input bit right_code);
      int                          slip;
      logic [kpl_pkg::KEY_W-1:0]   code;
      logic [kpl_pkg::DIGIT_W-1:0] value;
      logic [kpl_pkg::CHAR_W-1:0]  ch;
      bit                          found;
      slip = right_code ? -1 : int'($urandom_range(0, kpl_pkg::CODE_LENGTH - 1));
      for (int pos = 0; pos < kpl_pkg::CODE_LENGTH; pos++) begin
         if (pos == slip) begin
            do begin
               code = random_key();
               key_lookup(code, value, ch);
            end while (value == code_digit(pos));
         end else if (right_code || $urandom_range(0, 1) == 0) begin
            code = code_for(code_digit(pos), found);
            if (!found) code = random_key();
         end else begin
            code = random_key();
         end
         queue_press(code);
      end
   endtask

   // zero to four presses while open, then '#' to relock
   task automatic queue_open_run();
      int                          n;
      logic [kpl_pkg::KEY_W-1:0]   code;
      logic [kpl_pkg::DIGIT_W-1:0] value;
      logic [kpl_pkg::CHAR_W-1:0]  ch;
      n = int'($urandom_range(0, 4));
      repeat (n) begin
         do begin
            code = random_key();
            key_lookup(code, value, ch);
         end while (ch == kpl_pkg::HASH_CHAR);
         queue_press(code);
      end
      queue_press(HASH_KEY);
   endtask

   task automatic wait_idle();
      while (presses_taken != presses_queued || expected_words.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_code(input logic [kpl_pkg::CSR_IDX_W-1:0] idx,
                             input logic [kpl_pkg::DIGIT_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         kpl_pkg::CSR_CODE_FIRST:  lock_code[0] = val;
         kpl_pkg::CSR_CODE_SECOND: lock_code[1] = val;
         kpl_pkg::CSR_CODE_THIRD:  lock_code[2] = val;
         default: ;
      endcase
   endtask

   initial begin
      int                          stop_at;
      bit                          reachable;
      bit                          found;
      logic [kpl_pkg::KEY_W-1:0]   unused_code;
      logic [kpl_pkg::DIGIT_W-1:0] digit;
      int                          r;

      repeat (9) @(negedge clock);
      reset = 1'b0;

      // reset code 1-2-3: open, presses while open incl. junk codes, relock, bad entry
      queue_press(8'h18); queue_press(8'h14); queue_press(8'h12);
      queue_press(8'h84); queue_press(8'h88); queue_press(8'h11);
      queue_press(8'h00); queue_press(8'hFF); queue_press(HASH_KEY);
      queue_press(8'h00); queue_press(8'hFF); queue_press(HASH_KEY);
      wait_idle();

      // code 0-*-#
      write_code(kpl_pkg::CSR_CODE_FIRST, 6'h00);
      write_code(kpl_pkg::CSR_CODE_SECOND, 6'h2A);
      write_code(kpl_pkg::CSR_CODE_THIRD, 6'h23);
      queue_press(8'h84); queue_press(8'h88); queue_press(HASH_KEY); queue_press(HASH_KEY);
      wait_idle();
      // write to the unmapped index must leave the code alone
      write_code(CSR_UNMAPPED, kpl_pkg::DIGIT_W'($urandom_range(0, 63)));
      queue_press(8'h84); queue_press(8'h88); queue_press(HASH_KEY); queue_press(HASH_KEY);
      wait_idle();

      // all-ones code cannot be keyed in
      write_code(kpl_pkg::CSR_CODE_FIRST, 6'h3F);
      write_code(kpl_pkg::CSR_CODE_SECOND, 6'h3F);
      write_code(kpl_pkg::CSR_CODE_THIRD, 6'h3F);
      queue_press(8'h81); queue_press(8'h42); queue_press(8'h21);
      wait_idle();

      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3) calm = 1'b1;
         for (int i = 0; i < 3; i++) begin
            r = int'($urandom_range(0, 9));
            if (r < 7) key_lookup(KEY_CODES[$urandom_range(0, 15)], digit, unused_code[6:0]);
            else if (r == 7) digit = INVALID_KEY;
            else digit = kpl_pkg::DIGIT_W'($urandom_range(0, 63));
            write_code(kpl_pkg::CSR_IDX_W'(i), digit);
         end
         if ($urandom_range(0, 1) == 0)
            write_code(CSR_UNMAPPED, kpl_pkg::DIGIT_W'($urandom_range(0, 63)));
         reachable = 1'b1;
         for (int pos = 0; pos < kpl_pkg::CODE_LENGTH; pos++) begin
            unused_code = code_for(code_digit(pos), found);
            if (!found) reachable = 1'b0;
         end
         stop_at = presses_queued + 18;
         while (presses_queued < stop_at) begin
            if (reachable && $urandom_range(0, 9) < 6) begin
               queue_attempt(1'b1);
               queue_open_run();
            end else begin
               queue_attempt(1'b0);
            end
         end
         wait_idle();
      end

      repeat (10) @(negedge clock);
      if (errors == 0)
         $display("tb_keypad_passcode_lock OK");
      else
         $display("tb_keypad_passcode_lock NOT OK");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb_keypad_passcode_lock NOT OK");
      $finish;
   end

endmodule
